/* sv/blsi_pkg.sv */
package blsi_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int ACTION_W     = 3;
  localparam int VALUE_W      = 8;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 5;

  localparam logic [ACTION_W-1:0] ACT_APPEND       = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT       = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE_FRONT = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_REMOVE_BACK  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_ROTATE       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_APPEND,
    OP_INSERT,
    OP_SHIFT,
    OP_ROTATE
  } blsi_op_t;

  typedef struct packed {
    blsi_op_t                  op;
    logic signed [VALUE_W-1:0] value;
  } blsi_cmd_t;

endpackage

/* sv/blsi_in_if.sv */
interface blsi_in_if;
  import blsi_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface

/* sv/blsi_out_if.sv */
interface blsi_out_if;
  import blsi_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output status, output count, input ready);
  modport sink (input valid, input status, input count, output ready);
endinterface

/* sv/blsi_cell.sv */
module blsi_cell #(
  parameter int CAPACITY = blsi_pkg::CAPACITY_DEF,
  parameter int INDEX    = 0
) (
  input  logic                                clk,
  input  blsi_pkg::blsi_cmd_t                 cmd,
  input  logic [$clog2(CAPACITY+1)-1:0]       fill,
  input  logic signed [blsi_pkg::VALUE_W-1:0] left_data,
  input  logic signed [blsi_pkg::VALUE_W-1:0] right_data,
  input  logic                                found_in,
  output logic                                found_out,
  output logic signed [blsi_pkg::VALUE_W-1:0] data
);
  import blsi_pkg::*;

  localparam int FW = $clog2(CAPACITY + 1);

  logic                      occupied;
  logic                      at_fill;
  logic                      at_last;
  logic                      hit;
  logic signed [VALUE_W-1:0] data_next;

  assign occupied  = FW'(INDEX) < fill;
  assign at_fill   = fill == FW'(INDEX);
  assign at_last   = fill == FW'(INDEX + 1);
  // first slot whose entry is not below the value, or the slot past the back
  assign hit       = at_fill || (occupied && (cmd.value <= data));
  assign found_out = found_in || hit;

  always_comb begin
    data_next = data;
    unique case (cmd.op)
      OP_HOLD: ;
      OP_APPEND: begin
        if (at_fill) data_next = cmd.value;
      end
      OP_INSERT: begin
        if (found_in) data_next = left_data;
        else if (hit) data_next = cmd.value;
      end
      OP_SHIFT: data_next = right_data;
      OP_ROTATE: begin
        data_next = at_last ? cmd.value : right_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

/* sv/byte_list_with_sorted_insert.sv */
// Ordered list of up to CAPACITY signed bytes, held in a row of cells.
// One word in on items gives one word out on results: a status (ok, empty,
// no match, full) and the count after the action, modulo 32. Each action's
// result is registered, so the block takes one item every cycle while
// results are drained; items stall only while a result waits to be taken.
// The insert position is found by a priority chain that ripples through
// all cells combinationally, which sets the clock limit.
module byte_list_with_sorted_insert #(
  parameter int CAPACITY = blsi_pkg::CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  blsi_in_if.sink   items,
  blsi_out_if.source results
);
  import blsi_pkg::*;

  localparam int FW = $clog2(CAPACITY + 1);

  logic [FW-1:0]             fill;
  logic [FW-1:0]             fill_next;
  logic [STATUS_W-1:0]       status_next;
  blsi_op_t                  op;
  blsi_cmd_t                 cmd;
  logic                      accept;
  logic                      empty;
  logic                      full;
  logic signed [VALUE_W-1:0] front;
  logic signed [VALUE_W-1:0] back;
  logic signed [VALUE_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY:0]         found;

  assign items.ready = !results.valid || results.ready;
  assign accept      = items.valid && items.ready;
  assign empty       = fill == '0;
  assign full        = fill == FW'(CAPACITY);
  assign front       = cell_data[0];

  always_comb begin
    back = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (fill == FW'(i + 1)) back = back | cell_data[i];
    end
  end

  always_comb begin
    status_next = ST_OK;
    fill_next   = fill;
    op          = OP_HOLD;
    unique case (items.action)
      ACT_APPEND, ACT_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          op        = (items.action == ACT_APPEND) ? OP_APPEND : OP_INSERT;
          fill_next = fill + 1'b1;
        end
      end
      ACT_REMOVE_FRONT, ACT_ROTATE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (front != items.value) begin
          status_next = ST_NOMATCH;
        end else if (items.action == ACT_ROTATE) begin
          op = OP_ROTATE;
        end else begin
          op        = OP_SHIFT;
          fill_next = fill - 1'b1;
        end
      end
      ACT_REMOVE_BACK: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else if (back != items.value) begin
          status_next = ST_NOMATCH;
        end else begin
          fill_next = fill - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign cmd.op    = accept ? op : OP_HOLD;
  assign cmd.value = items.value;
  assign found[0]  = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [VALUE_W-1:0] left_data;
    logic signed [VALUE_W-1:0] right_data;

    if (g == 0) begin : g_first
      assign left_data = items.value;
    end else begin : g_mid_l
      assign left_data = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[g];
    end else begin : g_mid_r
      assign right_data = cell_data[g+1];
    end

    blsi_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .fill       (fill),
      .left_data  (left_data),
      .right_data (right_data),
      .found_in   (found[g]),
      .found_out  (found[g+1]),
      .data       (cell_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      results.valid <= 1'b0;
    end else begin
      if (accept) begin
        fill          <= fill_next;
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      results.status <= status_next;
      results.count  <= COUNT_W'(fill_next);
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(CAPACITY))
    else $error("fill above capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> results.valid)
    else $error("accepted word gave no result");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && items.action == ACT_APPEND && !full) |=> fill == FW'($past(fill) + 1'b1))
    else $error("append did not grow list");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status == ST_FULL) |-> full)
    else $error("full status on list not full");
`endif

endmodule
